// ----- rtl/gfb_pkg.sv -----
// shared types and constants for the glyph framebuffer blitter
package gfb_pkg;

  // default geometry
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int GLYPH_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // register reset values and limits
  localparam logic [4:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [5:0] FONT_HEIGHT_RST = 6'd10;
  localparam logic [5:0] MAX_HEIGHT      = 6'd32;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;

  typedef enum logic [1:0] {
    REG_FONT_WIDTH  = 2'd0,
    REG_FONT_HEIGHT = 2'd1,
    REG_INVERT_MODE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_SET_CURSOR = 2'd0,
    CMD_FILL       = 2'd1,
    CMD_GLYPH_ROW  = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [4:0] font_width;
    logic [5:0] font_height;
    logic       invert_mode;
  } cfg_t;

  // one unit of work handed from the front end to the back end
  typedef struct packed {
    cmd_t        op;
    logic        color;     // fill colour, or foreground after invert
    logic        paint;     // glyph row is drawn
    logic [6:0]  x;
    logic [6:0]  y;
    logic [4:0]  width;
    logic [15:0] glyph;
    logic [9:0]  addr;
    logic        done;
    logic        rejected;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FILL,
    B_ROW,
    B_READ,
    B_RESP
  } back_state_t;

endpackage

// ----- rtl/glyph_framebuffer_blitter_core.sv -----
// top level: glyph framebuffer blitter with config registers, front end, queue and back end
//
// Usage: items enter on in_valid/in_stall with cmd, pos_x, pos_y, color, glyph_row and
// read_addr; each item gives exactly one result on out_valid/out_stall carrying read_data,
// char_done and char_rejected. An item is taken at an edge where valid is high and stall low.
// Commands: set cursor, fill whole store, draw one glyph row at the cursor, read one byte.
// Registers font_width (0x0), font_height (0x4) and invert_mode (0x8) are written over the
// APB-style port; change them only while the block is idle.
// Flow: the front end takes an item and queues it; the back end works through one queued
// item at a time. A drawn glyph row does one frame store read-modify-write per pixel, the
// read of the next pixel overlapping the write of the last; a rejected or zero-width glyph
// row writes nothing; fill writes the whole store at one byte per cycle.
// Reset: registers take their defaults, the cursor goes home, and a clearing pass over all
// STORE_BYTES bytes (1024 at 128x64) blanks the frame store; in_stall stays high meanwhile.
// Receiver stall: the result register holds; the back end waits in its response step while
// the front end keeps taking items until the queue is full.
module glyph_framebuffer_blitter_core #(
  parameter int SCREEN_WIDTH  = gfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gfb_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_BITS    = gfb_pkg::GLYPH_BITS_DEF,
  parameter int QUEUE_DEPTH   = gfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [6:0]  pos_x,
  input  logic [5:0]  pos_y,
  input  logic        color,
  input  logic [15:0] glyph_row,
  input  logic [9:0]  read_addr,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        char_done,
  output logic        char_rejected,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gfb_pkg::cfg_t      cfg;
  gfb_pkg::desc_t     push_desc;
  gfb_pkg::desc_t     head_desc;
  gfb_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic               clearing;
  logic               cfg_we;
  gfb_pkg::reg_idx_t  reg_idx;

  // register port, always ready
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = gfb_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.font_width  <= gfb_pkg::FONT_WIDTH_RST;
      cfg.font_height <= gfb_pkg::FONT_HEIGHT_RST;
      cfg.invert_mode <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        gfb_pkg::REG_FONT_WIDTH:  cfg.font_width  <= pwdata[4:0];
        gfb_pkg::REG_FONT_HEIGHT: cfg.font_height <= pwdata[5:0];
        gfb_pkg::REG_INVERT_MODE: cfg.invert_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gfb_pkg::REG_FONT_WIDTH:  prdata = {27'd0, cfg.font_width};
      gfb_pkg::REG_FONT_HEIGHT: prdata = {26'd0, cfg.font_height};
      gfb_pkg::REG_INVERT_MODE: prdata = {31'd0, cfg.invert_mode};
      default:                  prdata = 32'd0;
    endcase
  end

  // front end: accept, cursor tracking, fit test
  gfb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .color     (color),
    .glyph_row (glyph_row),
    .read_addr (read_addr),
    .cfg       (cfg),
    .q_status  (q_status),
    .clearing  (clearing),
    .push      (push),
    .desc      (push_desc)
  );

  // decouples item intake from frame store work
  gfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .status    (q_status)
  );

  // back end: frame store and result register
  gfb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_BITS    (GLYPH_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_desc        (head_desc),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .char_done     (char_done),
    .char_rejected (char_rejected)
  );

endmodule

// ----- rtl/gfb_front.sv -----
// front end: accepts items, tracks the text cursor and classifies work
module gfb_front #(
  parameter int SCREEN_WIDTH  = gfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [6:0]        pos_x,
  input  logic [5:0]        pos_y,
  input  logic              color,
  input  logic [15:0]       glyph_row,
  input  logic [9:0]        read_addr,
  input  gfb_pkg::cfg_t     cfg,
  input  gfb_pkg::q_status_t q_status,
  input  logic              clearing,
  output logic              push,
  output gfb_pkg::desc_t    desc
);

  logic [6:0] cursor_col;
  logic [5:0] cursor_row;
  logic [4:0] glyph_row_index;
  logic       char_skip;

  logic [5:0] h_eff;
  logic [8:0] col_sum;
  logic [7:0] row_sum;
  logic       no_fit;
  logic       skip_now;
  logic [5:0] idx_inc;
  logic       last_row;
  gfb_pkg::cmd_t op;

  assign in_stall = q_status.full || clearing;
  assign push     = in_valid && !in_stall;
  assign op       = gfb_pkg::cmd_t'(cmd);

  always_comb begin
    if (cfg.font_height == 6'd0) begin
      h_eff = 6'd1;
    end else if (cfg.font_height > gfb_pkg::MAX_HEIGHT) begin
      h_eff = gfb_pkg::MAX_HEIGHT;
    end else begin
      h_eff = cfg.font_height;
    end
  end

  // fit test, only taken on the first row of a character
  assign col_sum  = {2'b00, cursor_col} + {4'b0000, cfg.font_width};
  assign row_sum  = {2'b00, cursor_row} + {2'b00, h_eff};
  assign no_fit   = (col_sum >= 9'(SCREEN_WIDTH)) || (row_sum >= 8'(SCREEN_HEIGHT));
  assign skip_now = (glyph_row_index == 5'd0) ? no_fit : char_skip;
  assign idx_inc  = {1'b0, glyph_row_index} + 6'd1;
  assign last_row = idx_inc >= h_eff;

  always_comb begin
    desc.op       = op;
    desc.color    = (op == gfb_pkg::CMD_FILL) ? color : (color ^ cfg.invert_mode);
    desc.paint    = !skip_now;
    desc.x        = cursor_col;
    desc.y        = {1'b0, cursor_row} + {2'b00, glyph_row_index};
    desc.width    = cfg.font_width;
    desc.glyph    = glyph_row;
    desc.addr     = read_addr;
    desc.done     = (op == gfb_pkg::CMD_GLYPH_ROW) && last_row && !skip_now;
    desc.rejected = (op == gfb_pkg::CMD_GLYPH_ROW) && last_row && skip_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col      <= 7'd0;
      cursor_row      <= 6'd0;
      glyph_row_index <= 5'd0;
      char_skip       <= 1'b0;
    end else if (push) begin
      case (op)
        gfb_pkg::CMD_SET_CURSOR: begin
          cursor_col      <= pos_x;
          cursor_row      <= pos_y;
          glyph_row_index <= 5'd0;
          char_skip       <= 1'b0;
        end
        gfb_pkg::CMD_GLYPH_ROW: begin
          if (last_row) begin
            if (!skip_now) begin
              cursor_col <= cursor_col + {2'b00, cfg.font_width};
            end
            glyph_row_index <= 5'd0;
            char_skip       <= 1'b0;
          end else begin
            glyph_row_index <= idx_inc[4:0];
            char_skip       <= skip_now;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/gfb_queue.sv -----
// short work queue between front end and back end
module gfb_queue #(
  parameter int DEPTH = gfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gfb_pkg::desc_t     push_desc,
  input  logic               pop,
  output gfb_pkg::desc_t     head_desc,
  output gfb_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gfb_pkg::desc_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = count == CNT_W'(DEPTH);
  assign status.empty = count == '0;
  assign head_desc    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("queue read while empty");

endmodule

// ----- rtl/gfb_back.sv -----
// back end: frame store, clearing/fill sweep, pixel read-modify-write, result register
module gfb_back #(
  parameter int SCREEN_WIDTH  = gfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gfb_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_BITS    = gfb_pkg::GLYPH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  gfb_pkg::q_status_t q_status,
  input  gfb_pkg::desc_t     q_desc,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic               char_done,
  output logic               char_rejected
);

  localparam int STORE_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_wa;
  logic [ADDR_W-1:0] mem_ra;
  logic [7:0]        mem_wd;

  gfb_pkg::back_state_t state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic [4:0]        pix, pix_next;
  gfb_pkg::desc_t    cur;
  logic [15:0]       row_sh;

  // pixel write stage, acting in the cycle after the read
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [2:0]        wr_bit;
  logic              wr_white;

  logic [7:0]  px_x;
  logic [12:0] px_idx;
  logic        px_ok;
  logic        px_white;
  logic        rd_in_range;
  logic        load;
  logic [7:0]  bit_mask;

  assign px_x     = {1'b0, cur.x} + {3'b000, pix};
  assign px_idx   = 13'(px_x) + 13'(cur.y[6:3]) * 13'(SCREEN_WIDTH);
  assign px_ok    = ({1'b0, px_x} < 9'(SCREEN_WIDTH)) && (cur.y < 7'(SCREEN_HEIGHT))
                    && (px_idx < 13'(STORE_BYTES));
  assign px_white = row_sh[GLYPH_BITS-1] ? cur.color : ~cur.color;

  assign rd_in_range = {2'b00, cur.addr} < 12'(STORE_BYTES);
  assign bit_mask    = 8'b1 << wr_bit;
  assign load        = (state == gfb_pkg::B_RESP) && (!out_valid || !out_stall);
  assign clearing    = state == gfb_pkg::B_CLEAR;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pix_next   = pix;
    pop        = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = px_idx[ADDR_W-1:0];
    mem_we     = wr_pend;
    mem_wa     = wr_addr;
    mem_wd     = wr_white ? (rd_q | bit_mask) : (rd_q & ~bit_mask);
    case (state)
      gfb_pkg::B_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = cnt;
        mem_wd   = gfb_pkg::BYTE_BLACK;
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(STORE_BYTES - 1)) begin
          state_next = gfb_pkg::B_IDLE;
        end
      end
      gfb_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          pop      = 1'b1;
          cnt_next = '0;
          pix_next = 5'd0;
          case (q_desc.op)
            gfb_pkg::CMD_FILL:  state_next = gfb_pkg::B_FILL;
            gfb_pkg::CMD_READ:  state_next = gfb_pkg::B_READ;
            gfb_pkg::CMD_GLYPH_ROW: begin
              state_next = (q_desc.paint && q_desc.width != 5'd0) ? gfb_pkg::B_ROW
                                                                  : gfb_pkg::B_RESP;
            end
            default:            state_next = gfb_pkg::B_RESP;
          endcase
        end
      end
      gfb_pkg::B_FILL: begin
        mem_we   = 1'b1;
        mem_wa   = cnt;
        mem_wd   = cur.color ? gfb_pkg::BYTE_WHITE : gfb_pkg::BYTE_BLACK;
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(STORE_BYTES - 1)) begin
          state_next = gfb_pkg::B_RESP;
        end
      end
      gfb_pkg::B_ROW: begin
        mem_re   = 1'b1;
        pix_next = pix + 5'd1;
        if (pix == cur.width - 5'd1) begin
          state_next = gfb_pkg::B_RESP;
        end
      end
      gfb_pkg::B_READ: begin
        mem_re     = 1'b1;
        mem_ra     = ADDR_W'(cur.addr);
        state_next = gfb_pkg::B_RESP;
      end
      gfb_pkg::B_RESP: begin
        if (load) begin
          state_next = gfb_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = gfb_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gfb_pkg::B_CLEAR;
      cnt     <= '0;
      pix     <= 5'd0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      pix     <= pix_next;
      wr_pend <= (state == gfb_pkg::B_ROW) && px_ok;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr  <= px_idx[ADDR_W-1:0];
    wr_bit   <= cur.y[2:0];
    wr_white <= px_white;
    if (pop) begin
      cur    <= q_desc;
      row_sh <= q_desc.glyph;
    end else if (state == gfb_pkg::B_ROW) begin
      row_sh <= row_sh << 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data     <= (cur.op == gfb_pkg::CMD_READ && rd_in_range) ? rd_q
                                                                     : gfb_pkg::BYTE_BLACK;
      char_done     <= cur.done;
      char_rejected <= cur.rejected;
    end
  end

  a_wr_after_row: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(state == gfb_pkg::B_ROW))
    else $error("pixel write outside a glyph row");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("work taken during clearing pass");

  a_resp_delivers: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && state == gfb_pkg::B_IDLE)
    else $error("result not presented after response");

endmodule
